// ----- sv/pqms_pkg.sv -----
// ----------------------------------------------------------------------------
// pqms_pkg
// Shared types and constants for the min-scan priority queue: item
// payloads, stored entry layout, operation and status codes.
// ----------------------------------------------------------------------------
package pqms_pkg;

   // Field widths
   localparam int ELEM_W = 32;
   localparam int PRIO_W = 16;
   localparam int CAP_W  = 5;
   localparam int OCC_W  = 5;

   // Default storage depth and capacity after reset
   localparam int              DEPTH_DEFAULT = 16;
   localparam logic [CAP_W-1:0] CAP_RESET    = 5'd16;

   // Element returned by a dequeue on an empty queue
   localparam logic signed [ELEM_W-1:0] EMPTY_VALUE = -32'sd999;

   typedef enum logic [0:0] {
      OP_ENQUEUE = 1'b0,
      OP_DEQUEUE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      op_type                   operation;
      logic signed [ELEM_W-1:0] element;
      logic [PRIO_W-1:0]        priority_req;
   } req_payload_type;

   typedef struct packed {
      status_type               status;
      logic signed [ELEM_W-1:0] removed_element;
      logic [OCC_W-1:0]         occupancy;
   } rsp_payload_type;

   // One stored queue entry
   typedef struct packed {
      logic signed [ELEM_W-1:0] element;
      logic [PRIO_W-1:0]        prio;
   } entry_type;

endpackage

// ----- sv/pqms_if.sv -----
// ----------------------------------------------------------------------------
// pqms_if
// Valid/ready channels for request items and response items.
// ----------------------------------------------------------------------------
interface pqms_req_if import pqms_pkg::*; ();
   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface pqms_rsp_if import pqms_pkg::*; ();
   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ----- sv/pqms_mem.sv -----
// ----------------------------------------------------------------------------
// pqms_mem
// Entry store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pqms_mem import pqms_pkg::*; #(
   parameter int  DEPTH = DEPTH_DEFAULT,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic            clock,
   input  logic            wr_en,
   input  logic [AW-1:0]   wr_addr,
   input  entry_type       wr_data,
   input  logic [AW-1:0]   rd_addr,
   output entry_type       rd_data_ff
);

   entry_type mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, registered read data
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

endmodule

// ----- sv/pqms_ctrl.sv -----
// ----------------------------------------------------------------------------
// pqms_ctrl
// Sequencer: appends on enqueue, scans for the minimum priority and then
// shifts later entries down on dequeue. Holds the response register.
// ----------------------------------------------------------------------------
module pqms_ctrl import pqms_pkg::*; #(
   parameter int  DEPTH = DEPTH_DEFAULT,
   localparam int AW    = $clog2(DEPTH),
   localparam int CW    = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [CAP_W-1:0] cap,
   pqms_req_if.sink         req_ch,
   pqms_rsp_if.source       rsp_ch,
   output logic [AW-1:0]    mem_rd_addr,
   output logic             mem_wr_en,
   output logic [AW-1:0]    mem_wr_addr,
   output entry_type        mem_wr_data,
   input  entry_type        mem_rd_data
);

   localparam int LW = (CW > CAP_W) ? CW : CAP_W;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_SHIFT,
      S_FINISH
   } state_type;

   state_type                state_ff, state_in;
   logic [CW-1:0]            cnt_ff, cnt_in;
   logic [CW-1:0]            ptr_ff, ptr_in;
   logic                     rd_pend_ff, rd_pend_in;
   logic [CW-1:0]            rd_idx_ff, rd_idx_in;
   logic [PRIO_W-1:0]        best_prio_ff, best_prio_in;
   logic [CW-1:0]            best_pos_ff, best_pos_in;
   status_type               res_status_ff, res_status_in;
   logic signed [ELEM_W-1:0] res_elem_ff, res_elem_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_payload_type          rsp_data_ff, rsp_data_in;

   logic          accept;
   logic          full;
   logic          take;
   logic          last;
   logic          issue;
   logic [CW-1:0] cnt_m1;
   logic [CW-1:0] rd_idx_m1;
   logic [CW-1:0] sel_pos;

   assign req_ch.ready   = (state_ff == S_IDLE);
   assign accept         = req_ch.valid && req_ch.ready;
   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_data_ff;

   // capacity limit, never above DEPTH
   assign full = (LW'(cnt_ff) >= LW'(cap)) || (cnt_ff == CW'(DEPTH));

   assign cnt_m1    = cnt_ff - CW'(1);
   assign rd_idx_m1 = rd_idx_ff - CW'(1);
   assign issue     = (ptr_ff < cnt_ff);
   assign last      = rd_pend_ff && (rd_idx_ff == cnt_m1);
   // strict compare keeps the earliest entry on a tie
   assign take      = rd_pend_ff &&
                      ((rd_idx_ff == '0) || (mem_rd_data.prio < best_prio_ff));
   assign sel_pos   = take ? rd_idx_ff : best_pos_ff;

   // next-state logic
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      ptr_in        = ptr_ff;
      rd_pend_in    = rd_pend_ff;
      rd_idx_in     = rd_idx_ff;
      best_prio_in  = best_prio_ff;
      best_pos_in   = best_pos_ff;
      res_status_in = res_status_ff;
      res_elem_in   = res_elem_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      mem_rd_addr   = ptr_ff[AW-1:0];
      mem_wr_en     = 1'b0;
      mem_wr_addr   = rd_idx_m1[AW-1:0];
      mem_wr_data   = mem_rd_data;

      // response register drains independently
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            mem_rd_addr = '0;
            if (accept) begin
               res_status_in = ST_DONE;
               res_elem_in   = '0;
               state_in      = S_FINISH;
               if (req_ch.payload.operation == OP_ENQUEUE) begin
                  if (full) begin
                     res_status_in = ST_FULL;
                  end else begin
                     mem_wr_en   = 1'b1;
                     mem_wr_addr = cnt_ff[AW-1:0];
                     mem_wr_data = '{element: req_ch.payload.element,
                                     prio:    req_ch.payload.priority_req};
                     cnt_in      = cnt_ff + CW'(1);
                  end
               end else if (cnt_ff == '0) begin
                  res_status_in = ST_EMPTY;
                  res_elem_in   = EMPTY_VALUE;
               end else begin
                  // entry 0 read is issued this cycle
                  ptr_in     = CW'(1);
                  rd_pend_in = 1'b1;
                  rd_idx_in  = '0;
                  state_in   = S_SCAN;
               end
            end
         end

         S_SCAN: begin
            if (issue) begin
               ptr_in     = ptr_ff + CW'(1);
               rd_pend_in = 1'b1;
               rd_idx_in  = ptr_ff;
            end else begin
               rd_pend_in = 1'b0;
            end
            if (take) begin
               best_prio_in = mem_rd_data.prio;
               best_pos_in  = rd_idx_ff;
               res_elem_in  = mem_rd_data.element;
            end
            if (last) begin
               res_status_in = ST_DONE;
               rd_pend_in    = 1'b0;
               ptr_in        = sel_pos + CW'(1);
               if (sel_pos == cnt_m1) begin
                  cnt_in   = cnt_m1;
                  state_in = S_FINISH;
               end else begin
                  state_in = S_SHIFT;
               end
            end
         end

         S_SHIFT: begin
            if (issue) begin
               ptr_in     = ptr_ff + CW'(1);
               rd_pend_in = 1'b1;
               rd_idx_in  = ptr_ff;
            end else begin
               rd_pend_in = 1'b0;
            end
            // entry just read moves down one place
            if (rd_pend_ff) begin
               mem_wr_en = 1'b1;
            end
            if (last) begin
               cnt_in     = cnt_m1;
               rd_pend_in = 1'b0;
               state_in   = S_FINISH;
            end
         end

         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{status:          res_status_ff,
                                removed_element: res_elem_ff,
                                occupancy:       OCC_W'(cnt_ff)};
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         ptr_ff       <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         ptr_ff        <= ptr_in;
         rd_pend_ff    <= rd_pend_in;
         rd_idx_ff     <= rd_idx_in;
         best_prio_ff  <= best_prio_in;
         best_pos_ff   <= best_pos_in;
         res_status_ff <= res_status_in;
         res_elem_ff   <= res_elem_in;
         rsp_valid_ff  <= rsp_valid_in;
         rsp_data_ff   <= rsp_data_in;
      end
   end

endmodule

// ----- sv/priority_queue_min_scan_unit.sv -----
// ----------------------------------------------------------------------------
// priority_queue_min_scan_unit
// Array priority queue with a linear minimum scan over an entry memory.
// ----------------------------------------------------------------------------
// Each request item is an enqueue or a dequeue and yields one response item.
// An enqueue, and a dequeue of an empty queue, go from acceptance straight to
// the finish state that loads the response register. A dequeue of a queue
// holding N entries first scans the entries for the smallest priority
// (earliest entry wins a tie), then moves the later entries down one place,
// both paced by the single read port of the entry memory, and then loads the
// response. Items are handled one at a time, so the input is ready again the
// cycle after the response is loaded; a new item is taken while the previous
// response still waits in its output register, and loading stalls while that
// register is still full. The capacity register may be written only while the
// block is idle; capacities above DEPTH act as DEPTH, zero refuses every
// enqueue.
module priority_queue_min_scan_unit import pqms_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [CAP_W-1:0] csr_wr_data,
   pqms_req_if.sink         req_ch,
   pqms_rsp_if.source       rsp_ch
);

   localparam int AW = $clog2(DEPTH);

   logic [CAP_W-1:0] cap_ff;
   logic [AW-1:0]    mem_rd_addr;
   logic             mem_wr_en;
   logic [AW-1:0]    mem_wr_addr;
   entry_type        mem_wr_data;
   entry_type        mem_rd_data;

   // capacity register
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else if (csr_wr_en) begin
         cap_ff <= csr_wr_data;
      end
   end

   pqms_ctrl #(
      .DEPTH (DEPTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .cap         (cap_ff),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .mem_rd_addr (mem_rd_addr),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_data (mem_rd_data)
   );

   pqms_mem #(
      .DEPTH (DEPTH)
   ) u_mem (
      .clock      (clock),
      .wr_en      (mem_wr_en),
      .wr_addr    (mem_wr_addr),
      .wr_data    (mem_wr_data),
      .rd_addr    (mem_rd_addr),
      .rd_data_ff (mem_rd_data)
   );

endmodule
